FILE: rtl/tlmd_pkg.sv
// Shared constants and types for the type-length message deframer.
`timescale 1ns / 1ps
`default_nettype none

package tlmd_pkg;

    // Header geometry: type byte, length low, length high, then any padding up to HEADER_BYTES.
    localparam int HEADER_BYTES = 3;
    localparam int HDR_POS_W    = 4;
    localparam logic [HDR_POS_W-1:0] HDR_POS_TYPE    = HDR_POS_W'(0);
    localparam logic [HDR_POS_W-1:0] HDR_POS_LEN_LO  = HDR_POS_W'(1);
    localparam logic [HDR_POS_W-1:0] HDR_POS_LEN_HI  = HDR_POS_W'(2);
    localparam logic [HDR_POS_W-1:0] HDR_POS_LAST    = HDR_POS_W'(HEADER_BYTES - 1);

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RECONNECT_TYPE = CFG_IDX_W'(1);
    localparam logic [BYTE_W-1:0] DATA_TYPE_RESET      = 8'd1;
    localparam logic [BYTE_W-1:0] RECONNECT_TYPE_RESET = 8'd2;

    // Result kinds.
    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_RECONNECT = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_t;

endpackage : tlmd_pkg

`default_nettype wire

FILE: rtl/tlmd_parser.sv
// Header and payload parser: consumes one stream byte per transfer.
`timescale 1ns / 1ps
`default_nettype none

module tlmd_parser
    import tlmd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [BYTE_W-1:0] stream_byte,
    input  wire logic [BYTE_W-1:0] data_type_code,
    input  wire logic [BYTE_W-1:0] reconnect_type_code,
    output      logic              res_valid,
    output      result_t           res
);

    logic [HDR_POS_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic [BYTE_W-1:0]    msg_type_reg, msg_type_next;
    logic [BYTE_W-1:0]    len_lo_reg, len_lo_next;
    logic [LEN_W-1:0]     remaining_reg, remaining_next;
    logic                 in_payload_reg, in_payload_next;

    logic [BYTE_W-1:0]    type_now;
    logic [LEN_W-1:0]     len_now;
    logic                 last_byte;

    // Type and length as seen with the current byte folded in.
    assign type_now  = (hdr_pos_reg == HDR_POS_TYPE) ? stream_byte : msg_type_reg;
    assign len_now   = (hdr_pos_reg == HDR_POS_LEN_HI) ? {stream_byte, len_lo_reg}
                                                       : remaining_reg;
    assign last_byte = (remaining_reg <= LEN_W'(1));

    // Next state and result for the byte being transferred.
    always_comb
    begin
        hdr_pos_next    = hdr_pos_reg;
        msg_type_next   = msg_type_reg;
        len_lo_next     = len_lo_reg;
        remaining_next  = remaining_reg;
        in_payload_next = in_payload_reg;
        res_valid       = 1'b0;
        res             = '{kind: KIND_PAYLOAD, data: '0, last: 1'b0};

        if (push)
        begin
            if (in_payload_reg)
            begin
                res_valid      = 1'b1;
                res            = '{kind: KIND_PAYLOAD, data: stream_byte, last: last_byte};
                remaining_next = remaining_reg - LEN_W'(1);
                if (last_byte)
                begin
                    remaining_next  = '0;
                    in_payload_next = 1'b0;
                    hdr_pos_next    = HDR_POS_TYPE;
                end
            end
            else
            begin
                if (hdr_pos_reg == HDR_POS_TYPE)
                begin
                    msg_type_next = stream_byte;
                end
                if (hdr_pos_reg == HDR_POS_LEN_LO)
                begin
                    len_lo_next = stream_byte;
                end
                if (hdr_pos_reg == HDR_POS_LEN_HI)
                begin
                    remaining_next = {stream_byte, len_lo_reg};
                end

                if (hdr_pos_reg != HDR_POS_LAST)
                begin
                    hdr_pos_next = hdr_pos_reg + HDR_POS_W'(1);
                end
                else
                begin
                    // Header complete: reconnect wins over data when codes match.
                    hdr_pos_next = HDR_POS_TYPE;
                    if (type_now == reconnect_type_code)
                    begin
                        remaining_next = '0;
                        res_valid      = 1'b1;
                        res            = '{kind: KIND_RECONNECT, data: '0, last: 1'b0};
                    end
                    else if ((type_now == data_type_code) && (len_now != '0))
                    begin
                        remaining_next  = len_now;
                        in_payload_next = 1'b1;
                    end
                    else
                    begin
                        remaining_next = '0;
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg    <= HDR_POS_TYPE;
            msg_type_reg   <= '0;
            len_lo_reg     <= '0;
            remaining_reg  <= '0;
            in_payload_reg <= 1'b0;
        end
        else
        begin
            hdr_pos_reg    <= hdr_pos_next;
            msg_type_reg   <= msg_type_next;
            len_lo_reg     <= len_lo_next;
            remaining_reg  <= remaining_next;
            in_payload_reg <= in_payload_next;
        end
    end

    // The payload phase always has bytes left and starts at a header boundary.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (remaining_reg != '0 && hdr_pos_reg == HDR_POS_TYPE))
        else $error("payload phase with no bytes left or mid-header");

    // The header position never runs past the last header byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pos_reg <= HDR_POS_LAST)
        else $error("header position out of range");

    // A final payload byte returns the parser to the header phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_PAYLOAD && res.last) |=> !in_payload_reg)
        else $error("parser stayed in payload after last byte");

endmodule : tlmd_parser

`default_nettype wire

FILE: rtl/tlmd_out_buf.sv
// Result register with a skid stage between the parser and the output channel.
`timescale 1ns / 1ps
`default_nettype none

module tlmd_out_buf
    import tlmd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    input  wire result_t res,
    output      logic    can_accept,
    output      logic    out_valid,
    input  wire logic    out_ready,
    output      result_t out_res
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_res_reg, out_res_next;
    result_t skid_res_reg, skid_res_next;
    logic    out_free;

    assign out_free   = !out_valid_reg || out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_res    = out_res_reg;

    // Move the skid entry forward first; new results land in the free slot.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;

        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_res_next   = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_res_next   = res;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    // The skid entry is only ever filled behind a waiting output.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    // No new result arrives while the skid stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !res_valid)
        else $error("result lost on full skid stage");

endmodule : tlmd_out_buf

`default_nettype wire

FILE: rtl/type_length_message_deframer_unit.sv
// Top level of the type-length message deframer.
//
//  Channel   Signals                                         Direction
//  --------  ----------------------------------------------  ---------
//  input     in_valid, in_ready, stream_byte                 in
//  output    out_valid, out_ready, result_kind,              out
//            payload_byte, last_of_message
//  config    cfg_write_en, cfg_index, cfg_data               in
//
// One stream byte is taken per clock while in_ready is high; each result is registered before output.
// The parser state and result logic sit between the input and the result register.
// A skid stage behind the result register holds one more result when the output stalls.
// in_ready drops only when both result register and skid stage hold a result.
// Reset clears the parser to await a type byte and restores the default type codes.
`timescale 1ns / 1ps
`default_nettype none

module type_length_message_deframer_unit
    import tlmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire logic [BYTE_W-1:0]    stream_byte,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic                 result_kind,
    output      logic [BYTE_W-1:0]    payload_byte,
    output      logic                 last_of_message,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data
);

    logic [BYTE_W-1:0] data_type_reg;
    logic [BYTE_W-1:0] reconnect_type_reg;
    logic              push;
    logic              res_valid;
    result_t           res;
    result_t           out_res;
    logic              can_accept;

    assign in_ready = can_accept;
    assign push     = in_valid && can_accept;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_type_reg      <= DATA_TYPE_RESET;
            reconnect_type_reg <= RECONNECT_TYPE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_DATA_TYPE:      data_type_reg      <= cfg_data;
                CFG_RECONNECT_TYPE: reconnect_type_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    tlmd_parser u_parser (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .stream_byte         (stream_byte),
        .data_type_code      (data_type_reg),
        .reconnect_type_code (reconnect_type_reg),
        .res_valid           (res_valid),
        .res                 (res)
    );

    tlmd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .can_accept (can_accept),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res)
    );

    // Unpack the result onto the output ports.
    assign result_kind     = logic'(out_res.kind);
    assign payload_byte    = out_res.data;
    assign last_of_message = out_res.last;

endmodule : type_length_message_deframer_unit

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the type-length message deframer unit.
`timescale 1ns / 1ps

module testbench;
    import tlmd_pkg::*;

    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 in_valid        = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    stream_byte     = '0;
    logic                 out_valid;
    logic                 out_ready       = 1'b0;
    logic                 result_kind;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 last_of_message;
    logic                 cfg_write_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = CFG_DATA_TYPE;
    logic [BYTE_W-1:0]    cfg_data        = '0;

    type_length_message_deframer_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .stream_byte     (stream_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .payload_byte    (payload_byte),
        .last_of_message (last_of_message),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    // Mirror of the deframer: type codes, header position and payload count.
    logic [BYTE_W-1:0]    data_code      = DATA_TYPE_RESET;
    logic [BYTE_W-1:0]    reconnect_code = RECONNECT_TYPE_RESET;
    logic [HDR_POS_W-1:0] hdr_index      = HDR_POS_TYPE;
    logic [BYTE_W-1:0]    cur_type       = '0;
    logic [BYTE_W-1:0]    len_low        = '0;
    logic [LEN_W-1:0]     bytes_left     = '0;
    logic                 in_body        = 1'b0;
    result_t              awaited_results[$];

    // Stimulus control shared by the tests and the two handshake sides.
    bit          sender_steady = 1'b0;
    bit          ready_steady  = 1'b0;
    bit          valid_held    = 1'b0;
    int unsigned burst_left    = 0;
    int unsigned pending_gap   = 1;
    int unsigned sent_count    = 0;
    int          mismatch_count = 0;

    // Advance the mirrored deframer by one stream byte and queue any result it yields.
    function automatic void deframe_byte(input logic [BYTE_W-1:0] value);
        result_t res;
        if (in_body) begin
            res.kind = KIND_PAYLOAD;
            res.data = value;
            res.last = (bytes_left <= 1);
            awaited_results.push_back(res);
            bytes_left = bytes_left - 1'b1;
            if (res.last) begin
                bytes_left = '0;
                in_body    = 1'b0;
                hdr_index  = HDR_POS_TYPE;
            end
        end else begin
            case (hdr_index)
                HDR_POS_TYPE:   cur_type   = value;
                HDR_POS_LEN_LO: len_low    = value;
                HDR_POS_LEN_HI: bytes_left = {value, len_low};
                default:        ;
            endcase
            if (hdr_index != HDR_POS_LAST) begin
                hdr_index = hdr_index + 1'b1;
            end else begin
                // Header complete: reconnect wins over data when the codes match.
                hdr_index = HDR_POS_TYPE;
                if (cur_type == reconnect_code) begin
                    bytes_left = '0;
                    res.kind   = KIND_RECONNECT;
                    res.data   = '0;
                    res.last   = 1'b0;
                    awaited_results.push_back(res);
                end else if (cur_type == data_code && bytes_left != '0) begin
                    in_body = 1'b1;
                end else begin
                    bytes_left = '0;
                end
            end
        end
    endfunction

    // Receiver: ready follows a random bit pattern, reloaded when ready_tick wraps, or stays high when ready_steady.
    logic [5:0]  ready_tick    = '0;
    logic [31:0] ready_pattern = '1;

    always @(posedge clk)
    begin
        ready_tick <= ready_tick + 1'b1;
        if (ready_tick == 6'd0)
        begin
            case ($urandom_range(0, 2))
                0:       ready_pattern <= $urandom;
                1:       ready_pattern <= $urandom | $urandom;
                default: ready_pattern <= $urandom & $urandom;
            endcase
        end
        out_ready <= ready_steady ? 1'b1 : ready_pattern[ready_tick[4:0]];
    end

    // Each result transfer is compared with the oldest expected result.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with none expected: kind %0d byte %02h last %0d",
                             $time, result_kind, payload_byte, last_of_message);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result_kind !== want.kind || payload_byte !== want.data ||
                    last_of_message !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: mismatch: expected kind %0d byte %02h last %0d",
                                 $time, want.kind, want.data, want.last);
                        $display("    got kind %0d byte %02h last %0d",
                                 result_kind, payload_byte, last_of_message);
                    end
                end
            end
        end
    end

    // Offer one stream byte and wait for its transfer; unless sender_steady, bursts end in a random gap.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        if (pending_gap != 0)
        begin
            repeat (pending_gap) @(posedge clk);
            pending_gap = 0;
        end
        in_valid    <= 1'b1;
        stream_byte <= value;
        valid_held  = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        deframe_byte(value);
        sent_count++;
        if (!sender_steady)
        begin
            if (burst_left <= 1)
            begin
                in_valid    <= 1'b0;
                valid_held  = 1'b0;
                burst_left  = $urandom_range(1, 24);
                pending_gap = $urandom_range(1, 6);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Type byte, little-endian length, then any padding up to the header size.
    task automatic send_header(input logic [BYTE_W-1:0] msg_type, input logic [LEN_W-1:0] len);
        send_byte(msg_type);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        repeat (HEADER_BYTES - 3) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // Stop sending and wait until every expected result has been seen.
    task automatic drain_results();
        if (valid_held)
        begin
            in_valid    <= 1'b0;
            valid_held  = 1'b0;
            pending_gap = 1;
        end
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes are only to be issued while the deframer is idle; this task does not enforce it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                             input logic [BYTE_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= reg_index;
        cfg_data     <= value;
        @(posedge clk);
        if (reg_index == CFG_DATA_TYPE)
            data_code = value;
        else
            reconnect_code = value;
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // Reset type codes: data, reconnect, unknown and zero-length messages.
    task automatic test_default_codes();
        send_header(DATA_TYPE_RESET, 16'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        // The length of a reconnect message is ignored.
        send_header(RECONNECT_TYPE_RESET, 16'h0105);
        // An unknown type skips only its header.
        send_header(8'hFF, 16'hFFFF);
        // A zero-length data message produces nothing.
        send_header(DATA_TYPE_RESET, 16'd0);
        send_header(DATA_TYPE_RESET, 16'd1);
        send_byte(8'hFF);
        drain_results();
    endtask

    // Extreme and equal type codes.
    task automatic test_code_extremes();
        write_reg(CFG_DATA_TYPE, 8'h00);
        write_reg(CFG_RECONNECT_TYPE, 8'hFF);
        send_header(8'h00, 16'd1);
        send_byte(8'hA5);
        send_header(8'hFF, 16'hFFFF);
        send_header(DATA_TYPE_RESET, 16'd2);
        drain_results();
        // With equal codes the reconnect meaning takes precedence.
        write_reg(CFG_DATA_TYPE, 8'h7E);
        write_reg(CFG_RECONNECT_TYPE, 8'h7E);
        send_header(8'h7E, 16'd3);
        send_header(8'h7E, 16'd0);
        drain_results();
    endtask

    // Mostly well-formed messages with random content, under several code settings.
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned pick;
        int unsigned len;
        logic [BYTE_W-1:0] code;
        for (int phase = 0; phase < 5; phase++)
        begin
            code = BYTE_W'($urandom_range(0, 255));
            case (phase)
                0:
                begin
                    write_reg(CFG_DATA_TYPE, 8'h00);
                    write_reg(CFG_RECONNECT_TYPE, 8'hFF);
                    sender_steady = 1'b1;
                    ready_steady  = 1'b1;
                end
                1:
                begin
                    write_reg(CFG_DATA_TYPE, 8'hFF);
                    write_reg(CFG_RECONNECT_TYPE, 8'h00);
                    sender_steady = 1'b0;
                    ready_steady  = 1'b0;
                end
                2:
                begin
                    write_reg(CFG_DATA_TYPE, code);
                    write_reg(CFG_RECONNECT_TYPE, code + 8'($urandom_range(1, 255)));
                    sender_steady = 1'b0;
                    ready_steady  = 1'b1;
                end
                3:
                begin
                    write_reg(CFG_DATA_TYPE, code);
                    write_reg(CFG_RECONNECT_TYPE, code);
                    sender_steady = 1'b1;
                    ready_steady  = 1'b0;
                end
                default:
                begin
                    write_reg(CFG_DATA_TYPE, DATA_TYPE_RESET);
                    write_reg(CFG_RECONNECT_TYPE, RECONNECT_TYPE_RESET);
                    sender_steady = 1'b0;
                    ready_steady  = 1'b0;
                end
            endcase
            goal = sent_count + 340;
            while (sent_count < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    // Data message: mostly short, now and then with a non-zero high byte.
                    if ($urandom_range(0, 15) == 0)
                        len = $urandom_range(0, 600);
                    else
                        len = $urandom_range(0, 12);
                    send_header(data_code, LEN_W'(len));
                    repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)));
                end
                else if (pick < 70)
                begin
                    send_header(reconnect_code, LEN_W'($urandom));
                end
                else if (pick < 90)
                begin
                    send_header(BYTE_W'($urandom_range(0, 255)), LEN_W'($urandom));
                end
                else
                begin
                    // Stray byte that knocks the framing out of step.
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                end
            end
            drain_results();
        end
    endtask

    // A length with a non-zero high byte carries the payload count across a byte boundary.
    task automatic test_long_message();
        sender_steady = 1'b0;
        ready_steady  = 1'b0;
        send_header(data_code, 16'h0104);
        repeat (260) send_byte(BYTE_W'($urandom_range(0, 255)));
        send_header(reconnect_code, 16'h0000);
        drain_results();
    endtask

    // Test sequence.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_default_codes();
        test_code_extremes();
        test_random_traffic();
        test_long_message();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
